// ===== rtl/lsrc_pkg.sv =====
// package for the line segment rectangle clipper
// holds widths, outcode bits and shared types; no dependencies
`default_nettype none
package lsrc_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int MAX_PASSES  = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [3:0] CODE_LEFT   = 4'h1;
    localparam logic [3:0] CODE_RIGHT  = 4'h2;
    localparam logic [3:0] CODE_BOTTOM = 4'h4;
    localparam logic [3:0] CODE_TOP    = 4'h8;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture segment, compute codes
        logic start;    // begin a crossing on the chosen endpoint
        logic div_step; // one divider bit
        logic commit;   // write crossing point back
        logic finish;   // latch result
        logic vis;      // visible flag for finish
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       accept;
        logic       reject;
        logic       div_done;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/lsrc_if.sv =====
// valid/ready channel interface carrying one item payload
// depends on nothing
`default_nettype none
interface lsrc_if #(parameter int W = 64) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/line_segment_rect_clipper_top.sv =====
// Cohen-Sutherland segment clipper against a configurable window. One segment
// is worked at a time; each pass that moves an endpoint forms a product and
// then runs a bit-serial restoring divider, and a segment that is neither
// accepted nor rejected at once may take up to MAX_PASSES such passes.
// depends on lsrc_pkg, lsrc_if, lsrc_ctrl and lsrc_dp
`default_nettype none
module line_segment_rect_clipper_top #(
    parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH,
    parameter int MAX_PASSES  = lsrc_pkg::MAX_PASSES
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [lsrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [COORD_WIDTH-1:0]          i_cfg_data,
    lsrc_if.sink                           in_ch,
    lsrc_if.source                         out_ch
);
    lsrc_pkg::t_cmd  cmd;
    lsrc_pkg::t_stat stat;

    lsrc_ctrl #(.MAX_PASSES(MAX_PASSES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    lsrc_dp #(.CW(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_seg(in_ch.data), .i_cmd(cmd), .o_stat(stat), .o_res(out_ch.data)
    );
endmodule
`default_nettype wire

// ===== rtl/lsrc_ctrl.sv =====
// controller for the clipper: pass loop and divider sequencing
// depends on lsrc_pkg
`default_nettype none
module lsrc_ctrl #(
    parameter int MAX_PASSES = lsrc_pkg::MAX_PASSES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  lsrc_pkg::t_stat   i_stat,
    output lsrc_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_DIV, S_COMMIT, S_OUT} t_state;
    localparam int PW = $clog2(MAX_PASSES + 1);

    t_state        r_state;
    logic [PW-1:0] r_pass;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_DECIDE: begin
                // out of passes counts as a reject even if the last move landed inside
                if (r_pass == PW'(MAX_PASSES)) begin
                    o_cmd.finish = 1'b1;
                end else if (i_stat.accept) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.vis = 1'b1;
                end else if (i_stat.reject) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.start = 1'b1;
                end
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_COMMIT: o_cmd.commit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state <= S_DECIDE;
                    r_pass <= '0;
                end
                S_DECIDE: begin
                    if (o_cmd.finish) r_state <= S_OUT;
                    else r_state <= S_DIV;
                end
                S_DIV: if (i_stat.div_done) r_state <= S_COMMIT;
                S_COMMIT: begin
                    r_state <= S_DECIDE;
                    r_pass <= r_pass + 1'b1;
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lsrc_dp.sv =====
// datapath for the clipper: window, endpoints, outcodes, multiply and divider
// depends on lsrc_pkg
`default_nettype none
module lsrc_dp #(
    parameter int CW = lsrc_pkg::COORD_WIDTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [lsrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CW-1:0]         i_cfg_data,
    input  wire [4*CW-1:0]       i_seg,
    input  lsrc_pkg::t_cmd       i_cmd,
    output lsrc_pkg::t_stat      o_stat,
    output logic [4*(CW+1):0]    o_res
);
    localparam int EW = CW + 2;          // endpoint/edge width
    localparam int DW = CW + 2;          // delta and offset width
    localparam int PW2 = 2 * DW;         // product magnitude width
    localparam int CNT_W = $clog2(PW2 + 1);

    logic signed [CW-1:0] r_min_x, r_min_y;
    logic [CW-2:0]        r_w, r_h;
    logic signed [EW-1:0] r_sx, r_sy, r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [3:0]           r_ca, r_cb;
    logic                 r_sel_b, r_vert;  // vert: crossing on top/bottom edge
    logic signed [EW-1:0] r_edge;
    logic [PW2-1:0]       r_num;
    logic [DW-1:0]        r_den;
    logic [PW2-1:0]       r_rem;
    logic [PW2-1:0]       r_q;
    logic                 r_neg, r_zero;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_mul;
    logic signed [DW-1:0] r_ma, r_mb;
    logic [4*(CW+1):0]    r_res;

    logic signed [EW-1:0] x0, y0, x1, y1;
    assign x0 = EW'(r_min_x);
    assign y0 = EW'(r_min_y);
    assign x1 = x0 + EW'({1'b0, r_w});
    assign y1 = y0 + EW'({1'b0, r_h});

    function automatic logic [3:0] f_code(input logic signed [EW-1:0] x, y,
                                          input logic signed [EW-1:0] xa, ya, xb, yb);
        logic [3:0] c;
        c = '0;
        if (x < xa) c |= lsrc_pkg::CODE_LEFT;
        else if (x > xb) c |= lsrc_pkg::CODE_RIGHT;
        if (y < ya) c |= lsrc_pkg::CODE_BOTTOM;
        else if (y > yb) c |= lsrc_pkg::CODE_TOP;
        return c;
    endfunction

    assign o_stat.accept = ((r_ca | r_cb) == 4'h0);
    assign o_stat.reject = ((r_ca & r_cb) != 4'h0);
    assign o_stat.div_done = !r_mul && (r_cnt == '0);
    assign o_res = r_res;

    // crossing selection
    logic [3:0]           c_sel;
    logic                 c_vert;
    logic signed [EW-1:0] c_edge;
    always_comb begin
        c_sel = (r_ca > r_cb) ? r_ca : r_cb;
        c_vert = 1'b1;
        c_edge = x0;
        if ((c_sel & lsrc_pkg::CODE_TOP) != 0) c_edge = y1;
        else if ((c_sel & lsrc_pkg::CODE_BOTTOM) != 0) c_edge = y0;
        else begin
            c_vert = 1'b0;
            if ((c_sel & lsrc_pkg::CODE_RIGHT) != 0) c_edge = x1;
        end
    end

    logic signed [DW-1:0] off, num_d, den_d;
    assign off   = c_vert ? DW'(c_edge - r_sy) : DW'(c_edge - r_sx);
    assign num_d = c_vert ? r_dx : r_dy;
    assign den_d = c_vert ? r_dy : r_dx;

    logic [DW-1:0] mag_a, mag_b;
    assign mag_a = r_ma[DW-1] ? DW'(-r_ma) : DW'(r_ma);
    assign mag_b = r_mb[DW-1] ? DW'(-r_mb) : DW'(r_mb);

    logic [PW2:0] sh;
    assign sh = {r_rem, r_num[PW2-1]};

    // crossing point; the edge lies between the endpoints, so the quotient
    // never exceeds the segment delta and needs no saturation
    logic signed [EW-1:0] q_s, px, py;
    always_comb begin
        q_s = r_zero ? '0 : (r_neg ? EW'(-r_q) : EW'(r_q));
        if (r_vert) begin
            py = r_edge;
            px = r_sx + q_s;
        end else begin
            px = r_edge;
            py = r_sy + q_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_w <= '0;
            r_h <= '0;
            r_cnt <= '0;
            r_mul <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsrc_pkg::REG_MIN_X:  r_min_x <= i_cfg_data;
                    lsrc_pkg::REG_MIN_Y:  r_min_y <= i_cfg_data;
                    lsrc_pkg::REG_WIDTH:  r_w <= i_cfg_data[CW-2:0];
                    lsrc_pkg::REG_HEIGHT: r_h <= i_cfg_data[CW-2:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_mul <= 1'b1;
                r_cnt <= CNT_W'(PW2);
            end else if (r_mul) begin
                r_mul <= 1'b0;
            end else if (i_cmd.div_step && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= EW'($signed(i_seg[CW-1:0]));
            r_sy <= EW'($signed(i_seg[2*CW-1:CW]));
            r_ax <= EW'($signed(i_seg[CW-1:0]));
            r_ay <= EW'($signed(i_seg[2*CW-1:CW]));
            r_bx <= EW'($signed(i_seg[3*CW-1:2*CW]));
            r_by <= EW'($signed(i_seg[4*CW-1:3*CW]));
            r_dx <= DW'($signed(i_seg[3*CW-1:2*CW])) - DW'($signed(i_seg[CW-1:0]));
            r_dy <= DW'($signed(i_seg[4*CW-1:3*CW])) - DW'($signed(i_seg[2*CW-1:CW]));
            r_ca <= f_code(EW'($signed(i_seg[CW-1:0])), EW'($signed(i_seg[2*CW-1:CW])),
                           x0, y0, x1, y1);
            r_cb <= f_code(EW'($signed(i_seg[3*CW-1:2*CW])),
                           EW'($signed(i_seg[4*CW-1:3*CW])), x0, y0, x1, y1);
        end
        if (i_cmd.start) begin
            r_sel_b <= (c_sel != r_ca);
            r_vert <= c_vert;
            r_edge <= c_edge;
            r_ma <= num_d;
            r_mb <= off;
            r_den <= den_d[DW-1] ? DW'(-den_d) : DW'(den_d);
            r_zero <= (den_d == '0);
            r_neg <= (num_d[DW-1] ^ off[DW-1]) ^ den_d[DW-1];
            r_rem <= '0;
            r_q <= '0;
        end else if (r_mul) begin
            r_num <= PW2'(mag_a) * PW2'(mag_b);
        end else if (i_cmd.div_step && r_cnt != '0) begin
            // restoring division, one quotient bit per cycle
            r_num <= {r_num[PW2-2:0], 1'b0};
            if (sh >= (PW2+1)'(r_den)) begin
                r_rem <= PW2'(sh - (PW2+1)'(r_den));
                r_q <= {r_q[PW2-2:0], 1'b1};
            end else begin
                r_rem <= PW2'(sh);
                r_q <= {r_q[PW2-2:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            if (r_sel_b) begin
                r_bx <= px;
                r_by <= py;
                r_cb <= f_code(px, py, x0, y0, x1, y1);
            end else begin
                r_ax <= px;
                r_ay <= py;
                r_ca <= f_code(px, py, x0, y0, x1, y1);
            end
        end
        if (i_cmd.finish) begin
            if (i_cmd.vis)
                r_res <= {r_by[CW:0], r_bx[CW:0], r_ay[CW:0], r_ax[CW:0], 1'b1};
            else
                r_res <= '0;
        end
    end
endmodule
`default_nettype wire
